### rtl/core/qsg_pkg.sv
// Shared types, widths and divisor constants of the quadrature sine generator.
package qsg_pkg;

  localparam int unsigned FRAME_MAX = 1024;
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned COUNT_W   = 10;
  localparam int unsigned PHASE_W   = 32;
  localparam int unsigned ANGLE_W   = 31;
  localparam int unsigned SQR_W     = 32;
  localparam int unsigned TERM_W    = 31;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned N_CELLS   = 6;

  localparam logic [ANGLE_W-1:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [TERM_W-1:0]  ONE_Q30     = 31'h4000_0000;

  typedef enum logic [0:0] {
    CFG_PHASE_STEP   = 1'b0,
    CFG_FRAME_LENGTH = 1'b1
  } qsg_cfg_e;

  typedef struct packed {
    logic [1:0]         quad;
    logic [COUNT_W-1:0] index;
    logic               last;
  } qsg_side_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] a;
    logic [SQR_W-1:0]   a2;
    logic [TERM_W-1:0]  cos_t;
    logic [TERM_W-1:0]  sin_t;
    qsg_side_t          side;
  } qsg_flow_t;

  typedef struct packed {
    logic [7:0]  k;
    logic [31:0] recip;
    logic [5:0]  shift;
    logic        bypass;
  } qsg_div_t;

  localparam qsg_div_t COS_DIV [N_CELLS] = '{
    '{8'd132, 32'((64'd1 << 39) / 64'd132), 6'd39, 1'b0},
    '{8'd90,  32'((64'd1 << 38) / 64'd90),  6'd38, 1'b0},
    '{8'd56,  32'((64'd1 << 37) / 64'd56),  6'd37, 1'b0},
    '{8'd30,  32'((64'd1 << 36) / 64'd30),  6'd36, 1'b0},
    '{8'd12,  32'((64'd1 << 35) / 64'd12),  6'd35, 1'b0},
    '{8'd2,   32'((64'd1 << 32) / 64'd2),   6'd32, 1'b0}
  };

  // last sine cell only hands its term on
  localparam qsg_div_t SIN_DIV [N_CELLS] = '{
    '{8'd110, 32'((64'd1 << 38) / 64'd110), 6'd38, 1'b0},
    '{8'd72,  32'((64'd1 << 38) / 64'd72),  6'd38, 1'b0},
    '{8'd42,  32'((64'd1 << 37) / 64'd42),  6'd37, 1'b0},
    '{8'd20,  32'((64'd1 << 36) / 64'd20),  6'd36, 1'b0},
    '{8'd6,   32'((64'd1 << 34) / 64'd6),   6'd34, 1'b0},
    '{8'd1,   32'h8000_0000,                6'd31, 1'b1}
  };

endpackage

### rtl/core/qsg_lane.sv
// One series term step: multiply by a2, divide by a constant, subtract from one; in bypass, pass the term on.
module qsg_lane (
  input  logic                         clk_i,
  input  logic [2:0]                   en_i,
  input  logic [qsg_pkg::SQR_W-1:0]    a2_i,
  input  logic [qsg_pkg::TERM_W-1:0]   t_i,
  input  qsg_pkg::qsg_div_t            div_i,
  output logic [qsg_pkg::TERM_W-1:0]   t_o
);

  logic [62:0] prod1;
  logic [31:0] p1_d, p1_q;
  logic [63:0] prod2;
  logic [31:0] q0_d, q0_q, p2_q;
  logic [39:0] kq;
  logic [31:0] rem;
  logic [31:0] quot;
  logic [qsg_pkg::TERM_W-1:0] t_d, t_q;

  always_comb begin
    prod1 = a2_i * t_i;
    p1_d  = div_i.bypass ? 32'(t_i) : prod1[61:30];
    prod2 = p1_q * div_i.recip;
    q0_d  = 32'(prod2 >> div_i.shift);
    kq    = q0_q * div_i.k;
    rem   = p2_q - kq[31:0];
    quot  = q0_q + 32'(rem >= 32'(div_i.k));
    if (div_i.bypass) begin
      t_d = p2_q[qsg_pkg::TERM_W-1:0];
    end else if (quot > 32'(qsg_pkg::ONE_Q30)) begin
      t_d = '0;
    end else begin
      t_d = qsg_pkg::TERM_W'(32'(qsg_pkg::ONE_Q30) - quot);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p1_q <= p1_d;
    end
    if (en_i[1]) begin
      p2_q <= p1_q;
      q0_q <= q0_d;
    end
    if (en_i[2]) begin
      t_q <= t_d;
    end
  end

  assign t_o = t_q;

endmodule

### rtl/core/qsg_cell.sv
// Three-stage iteration cell: cosine and sine lanes plus the carried angle and sideband.
module qsg_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qsg_pkg::qsg_div_t   cos_div_i,
  input  qsg_pkg::qsg_div_t   sin_div_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  qsg_pkg::qsg_flow_t  flow_i,
  output logic                valid_o,
  input  logic                ready_i,
  output qsg_pkg::qsg_flow_t  flow_o
);

  logic [2:0] v_q;
  logic [2:0] rdy;
  logic [qsg_pkg::ANGLE_W-1:0] a_q  [3];
  logic [qsg_pkg::SQR_W-1:0]   a2_q [3];
  qsg_pkg::qsg_side_t          side_q [3];
  logic [qsg_pkg::TERM_W-1:0]  cos_t, sin_t;

  always_comb begin
    rdy[2] = !v_q[2] || ready_i;
    rdy[1] = !v_q[1] || rdy[2];
    rdy[0] = !v_q[0] || rdy[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      a_q[0]    <= flow_i.a;
      a2_q[0]   <= flow_i.a2;
      side_q[0] <= flow_i.side;
    end
    if (rdy[1]) begin
      a_q[1]    <= a_q[0];
      a2_q[1]   <= a2_q[0];
      side_q[1] <= side_q[0];
    end
    if (rdy[2]) begin
      a_q[2]    <= a_q[1];
      a2_q[2]   <= a2_q[1];
      side_q[2] <= side_q[1];
    end
  end

  qsg_lane u_cos_lane (
    .clk_i (clk_i),
    .en_i  (rdy),
    .a2_i  (flow_i.a2),
    .t_i   (flow_i.cos_t),
    .div_i (cos_div_i),
    .t_o   (cos_t)
  );

  qsg_lane u_sin_lane (
    .clk_i (clk_i),
    .en_i  (rdy),
    .a2_i  (flow_i.a2),
    .t_i   (flow_i.sin_t),
    .div_i (sin_div_i),
    .t_o   (sin_t)
  );

  always_comb begin
    flow_o.a     = a_q[2];
    flow_o.a2    = a2_q[2];
    flow_o.cos_t = cos_t;
    flow_o.sin_t = sin_t;
    flow_o.side  = side_q[2];
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[2];

endmodule

### rtl/core/qsg_front.sv
// Phase accumulator, frame counter, angle scaling and angle square stages.
module qsg_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [qsg_pkg::PHASE_W-1:0]  phase_step_i,
  input  logic [qsg_pkg::LEN_W-1:0]    frame_len_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         restart_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output qsg_pkg::qsg_flow_t           flow_o
);

  logic [qsg_pkg::PHASE_W-1:0] phase_acc_q, phase_acc_d, phase_cur;
  logic [qsg_pkg::COUNT_W-1:0] count_q, count_d, count_cur;
  logic                        last_cur;
  logic                        accept;
  logic                        rdy_f, rdy_1, rdy_2;

  logic                        vf_q, v1_q, v2_q;
  logic [qsg_pkg::PHASE_W-1:0] phase_f_q;
  logic [qsg_pkg::COUNT_W-1:0] index_f_q;
  logic                        last_f_q;
  logic [60:0]                 prod_a;
  logic [qsg_pkg::ANGLE_W-1:0] a_d, a1_q, a2s_q;
  qsg_pkg::qsg_side_t          side_d, side1_q, side2_q;
  logic [61:0]                 prod_sq;
  logic [qsg_pkg::SQR_W-1:0]   sq_d, sq_q;

  always_comb begin
    rdy_2  = !v2_q || ready_i;
    rdy_1  = !v1_q || rdy_2;
    rdy_f  = !vf_q || rdy_1;
    accept = in_valid_i && rdy_f;

    phase_cur = restart_i ? '0 : phase_acc_q;
    count_cur = restart_i ? '0 : count_q;
    last_cur  = ({1'b0, count_cur} + qsg_pkg::LEN_W'(1)) >= frame_len_i;

    phase_acc_d = phase_acc_q;
    count_d     = count_q;
    if (accept) begin
      if (last_cur) begin
        phase_acc_d = '0;
        count_d     = '0;
      end else begin
        phase_acc_d = phase_cur + phase_step_i;
        count_d     = count_cur + qsg_pkg::COUNT_W'(1);
      end
    end

    prod_a       = phase_f_q[29:0] * qsg_pkg::HALF_PI_Q30;
    a_d          = prod_a[60:30];
    side_d.quad  = phase_f_q[31:30];
    side_d.index = index_f_q;
    side_d.last  = last_f_q;

    prod_sq = a1_q * a1_q;
    sq_d    = prod_sq[61:30];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_acc_q <= '0;
      count_q     <= '0;
      vf_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
    end else begin
      phase_acc_q <= phase_acc_d;
      count_q     <= count_d;
      if (rdy_f) vf_q <= in_valid_i;
      if (rdy_1) v1_q <= vf_q;
      if (rdy_2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_f) begin
      phase_f_q <= phase_cur;
      index_f_q <= count_cur;
      last_f_q  <= last_cur;
    end
    if (rdy_1) begin
      a1_q    <= a_d;
      side1_q <= side_d;
    end
    if (rdy_2) begin
      a2s_q   <= a1_q;
      sq_q    <= sq_d;
      side2_q <= side1_q;
    end
  end

  always_comb begin
    flow_o.a     = a2s_q;
    flow_o.a2    = sq_q;
    flow_o.cos_t = qsg_pkg::ONE_Q30;
    flow_o.sin_t = qsg_pkg::ONE_Q30;
    flow_o.side  = side2_q;
  end

  assign in_ready_o = rdy_f;
  assign valid_o    = v2_q;

endmodule

### rtl/core/qsg_back.sv
// Final sine product, Q1.15 rounding with saturation, quadrant mapping and output register.
module qsg_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  qsg_pkg::qsg_flow_t            flow_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [qsg_pkg::SAMPLE_W-1:0]  cos_value_o,
  output logic [qsg_pkg::SAMPLE_W-1:0]  sin_value_o,
  output logic [qsg_pkg::COUNT_W-1:0]   sample_index_o,
  output logic                          frame_last_o
);

  localparam logic [1:0] QUAD_FIRST  = 2'd0;
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD  = 2'd2;
  localparam logic [1:0] QUAD_FOURTH = 2'd3;

  function automatic logic [14:0] to_q15(input logic [30:0] m);
    logic [16:0] r;
    r = 17'((32'(m) + 32'd16384) >> 15);
    return (r > 17'd32767) ? 15'h7FFF : r[14:0];
  endfunction

  logic                        v1_q, out_valid_q;
  logic                        rdy_1, rdy_2;
  logic [61:0]                 prod_s;
  logic [qsg_pkg::TERM_W-1:0]  s1_q, c1_q;
  qsg_pkg::qsg_side_t          side1_q;
  logic [qsg_pkg::SAMPLE_W-1:0] pos_s, neg_s, pos_c, neg_c;
  logic [qsg_pkg::SAMPLE_W-1:0] cos_d, sin_d, cos_q, sin_q;
  logic [qsg_pkg::COUNT_W-1:0]  index_q;
  logic                         last_q;

  always_comb begin
    rdy_2  = !out_valid_q || !out_stall_i;
    rdy_1  = !v1_q || rdy_2;
    prod_s = flow_i.a * flow_i.sin_t;

    pos_s = {1'b0, to_q15(s1_q)};
    pos_c = {1'b0, to_q15(c1_q)};
    neg_s = -pos_s;
    neg_c = -pos_c;
    case (side1_q.quad)
      QUAD_FIRST: begin
        cos_d = pos_c;
        sin_d = pos_s;
      end
      QUAD_SECOND: begin
        cos_d = neg_s;
        sin_d = pos_c;
      end
      QUAD_THIRD: begin
        cos_d = neg_c;
        sin_d = neg_s;
      end
      QUAD_FOURTH: begin
        cos_d = pos_s;
        sin_d = neg_c;
      end
      default: begin
        cos_d = pos_c;
        sin_d = pos_s;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy_1) v1_q        <= valid_i;
      if (rdy_2) out_valid_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_1) begin
      s1_q    <= prod_s[60:30];
      c1_q    <= flow_i.cos_t;
      side1_q <= flow_i.side;
    end
    if (rdy_2) begin
      cos_q   <= cos_d;
      sin_q   <= sin_d;
      index_q <= side1_q.index;
      last_q  <= side1_q.last;
    end
  end

  assign ready_o        = rdy_1;
  assign out_valid_o    = out_valid_q;
  assign cos_value_o    = cos_q;
  assign sin_value_o    = sin_q;
  assign sample_index_o = index_q;
  assign frame_last_o   = last_q;

endmodule

### rtl/core/quadrature_sine_generator_top.sv
// Quadrature sine generator: configuration registers, front end, iteration cells, output stage.
//
// Each transfer on the input channel yields one complex sample (cos, sin in Q1.15, at most
// 32767 in magnitude) of a 32-bit phase accumulator that advances by the phase step, together
// with its index in the frame and a flag on the frame's last sample. The block takes one item
// per clock unless a stall at the output backs up to the input. An item passes 23 register
// stages: three front stages (phase, angle scaling, angle square), six iteration cells of
// three stages each that evaluate the sine and cosine series one term per cell (the last
// cell hands the sine term on), and two output stages. Every stage holds its item
// independently, so empty stages keep filling while a result waits at the output. Write the
// registers only while no item is in flight.
module quadrature_sine_generator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [0:0]                    cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          restart_frame_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [15:0]            cos_value_o,
  output logic signed [15:0]            sin_value_o,
  output logic [9:0]                    sample_index_o,
  output logic                          frame_last_o
);

  logic [qsg_pkg::PHASE_W-1:0] phase_step_q;
  logic [qsg_pkg::LEN_W-1:0]   frame_length_q;
  logic [qsg_pkg::LEN_W-1:0]   len_eff;
  logic                        front_ready;

  logic               cell_valid [qsg_pkg::N_CELLS+1];
  logic               cell_ready [qsg_pkg::N_CELLS+1];
  qsg_pkg::qsg_flow_t cell_flow  [qsg_pkg::N_CELLS+1];

  logic [15:0] cos_raw, sin_raw;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q   <= '0;
      frame_length_q <= qsg_pkg::LEN_W'(256);
    end else if (cfg_valid_i) begin
      case (qsg_pkg::qsg_cfg_e'(cfg_index_i))
        qsg_pkg::CFG_PHASE_STEP:   phase_step_q   <= cfg_data_i;
        qsg_pkg::CFG_FRAME_LENGTH: frame_length_q <= cfg_data_i[qsg_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_length_q == '0) begin
      len_eff = qsg_pkg::LEN_W'(1);
    end else if (frame_length_q > qsg_pkg::LEN_W'(qsg_pkg::FRAME_MAX)) begin
      len_eff = qsg_pkg::LEN_W'(qsg_pkg::FRAME_MAX);
    end else begin
      len_eff = frame_length_q;
    end
  end

  qsg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .phase_step_i (phase_step_q),
    .frame_len_i  (len_eff),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (front_ready),
    .restart_i    (restart_frame_i),
    .valid_o      (cell_valid[0]),
    .ready_i      (cell_ready[0]),
    .flow_o       (cell_flow[0])
  );

  assign in_stall_o = !front_ready;

  for (genvar g = 0; g < qsg_pkg::N_CELLS; g++) begin : g_cell
    qsg_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cos_div_i (qsg_pkg::COS_DIV[g]),
      .sin_div_i (qsg_pkg::SIN_DIV[g]),
      .valid_i   (cell_valid[g]),
      .ready_o   (cell_ready[g]),
      .flow_i    (cell_flow[g]),
      .valid_o   (cell_valid[g+1]),
      .ready_i   (cell_ready[g+1]),
      .flow_o    (cell_flow[g+1])
    );
  end

  qsg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (cell_valid[qsg_pkg::N_CELLS]),
    .ready_o        (cell_ready[qsg_pkg::N_CELLS]),
    .flow_i         (cell_flow[qsg_pkg::N_CELLS]),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cos_value_o    (cos_raw),
    .sin_value_o    (sin_raw),
    .sample_index_o (sample_index_o),
    .frame_last_o   (frame_last_o)
  );

  assign cos_value_o = $signed(cos_raw);
  assign sin_value_o = $signed(sin_raw);

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (frame_last_o == (({1'b0, sample_index_o} + qsg_pkg::LEN_W'(1)) >= len_eff)))
    else $error("frame_last_o disagrees with sample_index_o and frame length");

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held output transfer");

  a_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cos_raw != 16'h8000 && sin_raw != 16'h8000))
    else $error("sample outside the saturated Q1.15 range");

endmodule

### test/tb_quadrature_sine_generator_top.sv
// Self-checking testbench of the quadrature sine generator with a sample scoreboard.
`timescale 1ns / 1ps

typedef struct {
  logic signed [15:0] cos_v;
  logic signed [15:0] sin_v;
  logic [9:0]         idx;
  logic               last;
} nco_sample_t;

class nco_sample_tracker;
  nco_sample_t pending[$];
  logic [31:0] step;
  logic [10:0] flen;
  logic [31:0] acc;
  int unsigned count;
  int unsigned errors;
  int unsigned ticks;
  int unsigned checked;
  int unsigned frame_ends;

  function new();
    step       = '0;
    flen       = 11'd256;
    acc        = '0;
    count      = 0;
    errors     = 0;
    ticks      = 0;
    checked    = 0;
    frame_ends = 0;
  endfunction

  function void set_reg(qsg_pkg::qsg_cfg_e idx, logic [31:0] data);
    case (idx)
      qsg_pkg::CFG_PHASE_STEP:   step = data;
      qsg_pkg::CFG_FRAME_LENGTH: flen = data[10:0];
      default: ;
    endcase
  endfunction

  function logic [63:0] series_term(logic [63:0] a2, logic [63:0] t, int unsigned k);
    logic [63:0] d;
    d = ((a2 * t) >> 30) / k;
    return (d > 64'h4000_0000) ? 64'd0 : 64'h4000_0000 - d;
  endfunction

  function int q15_of(logic [63:0] m);
    logic [63:0] r;
    r = (m + 64'd16384) >> 15;
    return (r > 64'd32767) ? 32767 : int'(r);
  endfunction

  function void sincos_q15(logic [31:0] ph, output int cv, output int sv);
    logic [63:0] x, a, a2, t;
    int c, s;
    x  = {34'd0, ph[29:0]};
    a  = (x * 64'd1686629713) >> 30;
    a2 = (a * a) >> 30;
    t  = (a2 / 110 > 64'h4000_0000) ? 64'd0 : 64'h4000_0000 - a2 / 110;
    t  = series_term(a2, t, 72);
    t  = series_term(a2, t, 42);
    t  = series_term(a2, t, 20);
    t  = series_term(a2, t, 6);
    s  = q15_of((a * t) >> 30);
    t  = (a2 / 132 > 64'h4000_0000) ? 64'd0 : 64'h4000_0000 - a2 / 132;
    t  = series_term(a2, t, 90);
    t  = series_term(a2, t, 56);
    t  = series_term(a2, t, 30);
    t  = series_term(a2, t, 12);
    t  = series_term(a2, t, 2);
    c  = q15_of(t);
    case (ph[31:30])
      2'd0: begin cv = c;  sv = s;  end
      2'd1: begin cv = -s; sv = c;  end
      2'd2: begin cv = -c; sv = -s; end
      default: begin cv = s; sv = -c; end
    endcase
  endfunction

  function void note_tick(logic restart);
    int unsigned len;
    nco_sample_t e;
    int cv, sv;
    len = (flen == 0) ? 1 : ((flen > 1024) ? 1024 : flen);
    if (restart) begin
      acc   = '0;
      count = 0;
    end
    sincos_q15(acc, cv, sv);
    e.cos_v = cv[15:0];
    e.sin_v = sv[15:0];
    e.idx   = count[9:0];
    e.last  = (count + 1 >= len);
    pending.push_back(e);
    ticks++;
    if (e.last) begin
      acc   = '0;
      count = 0;
    end else begin
      acc   = acc + step;
      count = count + 1;
    end
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task check_sample(logic signed [15:0] cv, logic signed [15:0] sv, logic [9:0] idx,
                    logic last);
    nco_sample_t e;
    if (pending.size() == 0) begin
      report($sformatf("sample cos=%0d sin=%0d idx=%0d with nothing pending", cv, sv, idx));
      return;
    end
    e = pending.pop_front();
    checked++;
    if (last) frame_ends++;
    if (cv !== e.cos_v) report($sformatf("cos %0d, want %0d", cv, e.cos_v));
    if (sv !== e.sin_v) report($sformatf("sin %0d, want %0d", sv, e.sin_v));
    if (idx !== e.idx) report($sformatf("sample_index %0d, want %0d", idx, e.idx));
    if (last !== e.last) report($sformatf("frame_last %0b, want %0b", last, e.last));
  endtask
endclass

module tb_quadrature_sine_generator_top;

  localparam int unsigned LATENCY   = 23;
  localparam int unsigned MAX_TICKS = 1710;
  localparam longint     LIMIT     = 400000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [0:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               restart_frame_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] cos_value_o;
  logic signed [15:0] sin_value_o;
  logic [9:0]         sample_index_o;
  logic               frame_last_o;

  nco_sample_tracker sb;
  longint            cycle_count;
  int                hold_cycles;
  bit                sender_idle;
  bit                receiver_idle;
  int unsigned       reg_writes;

  quadrature_sine_generator_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .restart_frame_i (restart_frame_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cos_value_o     (cos_value_o),
    .sin_value_o     (sin_value_o),
    .sample_index_o  (sample_index_o),
    .frame_last_o    (frame_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial cycle_count = 0;
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECKS FAILED");
    $finish;
  end

  // hold off for a counted stretch when asked, else stall at random while the receiver may idle
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_stall_i <= receiver_idle && ($urandom_range(99) < 21);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_tick(restart_frame_i);
      if (out_valid_o && !out_stall_i)
        sb.check_sample(cos_value_o, sin_value_o, sample_index_o, frame_last_o);
    end
  end

  task automatic send_tick(input logic restart);
    while (sender_idle && ($urandom_range(99) < 21)) begin
      in_valid_i      <= 1'b0;
      restart_frame_i <= 1'($urandom_range(1));
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    restart_frame_i <= restart;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  // hold valid across back-to-back writes; the caller drops it afterwards
  task automatic write_reg(input qsg_pkg::qsg_cfg_e idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    reg_writes++;
  endtask

  task automatic run_ticks(input int n, input int restart_pct);
    for (int i = 0; i < n; i++) send_tick($urandom_range(99) < restart_pct);
  endtask

  function automatic logic [31:0] pick_step();
    logic [63:0] f;
    f = 64'($urandom_range(1, 3999));
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'((f << 32) / 64'd8000);
      2: return 32'd0;
      3: return 32'hFFFF_FFFF;
      4: return 32'h8000_0000;
      default: return $urandom_range(1, 1000);
    endcase
  endfunction

  function automatic logic [31:0] pick_length();
    logic [10:0] len;
    case ($urandom_range(7))
      0, 1, 2: len = 11'($urandom_range(1, 64));
      3: len = 11'($urandom_range(1, 1024));
      4: len = 11'd1;
      5: len = 11'd1024;
      6: len = 11'd0;
      default: len = 11'($urandom_range(1025, 2047));
    endcase
    return {21'($urandom()), len};
  endfunction

  initial begin
    int n;
    sb              = new();
    hold_cycles     = 0;
    sender_idle     = 1'b1;
    receiver_idle   = 1'b1;
    reg_writes      = 0;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = qsg_pkg::CFG_PHASE_STEP;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    restart_frame_i = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (LATENCY) @(posedge clk_i);

    // reset settings: zero step, 256-sample frame
    send_tick(1'b0);
    send_tick(1'b1);

    // quarter-turn step across all quadrants, length with stray upper data bits
    quiesce();
    write_reg(qsg_pkg::CFG_PHASE_STEP, 32'h4000_0000);
    write_reg(qsg_pkg::CFG_FRAME_LENGTH, 32'hFFFF_F805);
    cfg_valid_i <= 1'b0;
    repeat (6) send_tick(1'b0);

    // zero length acts as one: every sample ends its frame
    quiesce();
    write_reg(qsg_pkg::CFG_PHASE_STEP, 32'hFFFF_FFFF);
    write_reg(qsg_pkg::CFG_FRAME_LENGTH, 32'd0);
    cfg_valid_i <= 1'b0;
    repeat (3) send_tick(1'b0);

    // largest angle inside a quadrant, oversize length clipped to the maximum
    quiesce();
    write_reg(qsg_pkg::CFG_PHASE_STEP, 32'h3FFF_FFFF);
    write_reg(qsg_pkg::CFG_FRAME_LENGTH, 32'd2047);
    cfg_valid_i <= 1'b0;
    repeat (4) send_tick(1'b0);

    // shorten the frame below the current index
    quiesce();
    write_reg(qsg_pkg::CFG_FRAME_LENGTH, 32'd3);
    cfg_valid_i <= 1'b0;
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);

    // long hold-off at the output while the input keeps offering
    quiesce();
    write_reg(qsg_pkg::CFG_PHASE_STEP, $urandom());
    write_reg(qsg_pkg::CFG_FRAME_LENGTH, 32'd40);
    cfg_valid_i <= 1'b0;
    sender_idle = 1'b0;
    hold_cycles = 300;
    run_ticks(100, 3);
    sender_idle = 1'b1;

    // stretch without idling on either side
    quiesce();
    write_reg(qsg_pkg::CFG_PHASE_STEP, pick_step());
    write_reg(qsg_pkg::CFG_FRAME_LENGTH, pick_length());
    cfg_valid_i <= 1'b0;
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    run_ticks(200, 3);
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;

    while (sb.ticks < MAX_TICKS) begin
      quiesce();
      if ($urandom_range(9) < 7) write_reg(qsg_pkg::CFG_PHASE_STEP, pick_step());
      if ($urandom_range(9) < 7) write_reg(qsg_pkg::CFG_FRAME_LENGTH, pick_length());
      cfg_valid_i <= 1'b0;
      n = $urandom_range(10, 80);
      run_ticks(n, 4);
    end

    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
    if (sb.pending.size() != 0) sb.report("samples still pending at the end");

    $display("Sent %0d ticks over %0d register writes, checked %0d samples, %0d frame ends.",
             sb.ticks, reg_writes, sb.checked, sb.frame_ends);
    $display("Mismatches: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/qsg_pkg.sv
rtl/core/qsg_lane.sv
rtl/core/qsg_cell.sv
rtl/core/qsg_front.sv
rtl/core/qsg_back.sv
rtl/core/quadrature_sine_generator_top.sv
test/tb_quadrature_sine_generator_top.sv
